// ----- rtl/core/sm3_pkg.sv -----
// Package: SM3 constants, helper functions and control structs.
package sm3_pkg;

  localparam logic [31:0] TJ_LOW   = 32'h79cc4519;
  localparam logic [31:0] TJ_HIGH  = 32'h7a879d8a;
  localparam logic [7:0]  PAD_MARK = 8'h80;

  localparam logic [255:0] SM3_IV = {
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
  };

  // Buffer byte source selected by the controller
  typedef enum logic [1:0] {
    BSEL_MSG  = 2'd0,
    BSEL_PAD  = 2'd1,
    BSEL_ZERO = 2'd2,
    BSEL_LEN  = 2'd3
  } bsel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic       buf_we;
    bsel_e      buf_sel;
    logic [5:0] buf_addr;
    logic       cnt_add;
    logic       cnt_clr;
    logic       len_cap;
    logic       blk_load;
    logic       round_en;
    logic [5:0] round_idx;
    logic       cv_update;
    logic       cv_reset;
  } sm3_cmd_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
  endfunction

endpackage

// ----- rtl/core/sm3_if.sv -----
// Interfaces: input byte channel and digest word channel.
interface sm3_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] message_byte;
  logic       final_byte;
  modport source (output valid, message_byte, final_byte, input ready);
  modport sink   (input valid, message_byte, final_byte, output ready);
endinterface

interface sm3_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- rtl/core/sm3_datapath.sv -----
// Datapath: bit counter, message and expansion window, round logic, chaining value.
module sm3_datapath import sm3_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sm3_cmd_t    cmd_i,
  input  logic [7:0]  msg_byte_i,
  input  logic [2:0]  rd_idx_i,
  output logic [5:0]  pos_o,
  output logic [31:0] cv_word_o
);

  logic [63:0]  cnt_q, cnt_d;
  logic [63:0]  len_q;
  logic [31:0]  w_q [16];
  logic [31:0]  r_q [8];
  logic [255:0] cv_q;
  logic [7:0]   wr_byte;
  logic [2:0]   len_sel;

  assign pos_o   = cnt_q[8:3];
  assign len_sel = cmd_i.buf_addr[2:0];

  // Buffer write data select
  always_comb begin
    case (cmd_i.buf_sel)
      BSEL_MSG:  wr_byte = msg_byte_i;
      BSEL_PAD:  wr_byte = PAD_MARK;
      BSEL_ZERO: wr_byte = 8'h00;
      BSEL_LEN:  wr_byte = len_q[63 - 8*len_sel -: 8];
      default:   wr_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.len_cap) len_q <= cnt_q;
  end

  // Bit counter
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_add) cnt_d = cnt_q + 64'd8;
    if (cmd_i.cnt_clr) cnt_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else         cnt_q <= cnt_d;
  end

  // One compression round
  logic [31:0] wj, wj4, a12, tj, ss1, ss2, ff, gg, tt1, tt2, nxt;
  logic [3:0]  j4;
  always_comb begin
    j4  = cmd_i.round_idx[3:0];
    wj  = w_q[j4];
    wj4 = w_q[j4 + 4'd4];
    a12 = rotl32(r_q[0], 5'd12);
    tj  = (cmd_i.round_idx < 6'd16) ? TJ_LOW : TJ_HIGH;
    ss1 = rotl32(a12 + r_q[4] + rotl32(tj, cmd_i.round_idx[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    if (cmd_i.round_idx < 6'd16) begin
      ff = r_q[0] ^ r_q[1] ^ r_q[2];
      gg = r_q[4] ^ r_q[5] ^ r_q[6];
    end else begin
      ff = (r_q[0] & r_q[1]) | (r_q[0] & r_q[2]) | (r_q[1] & r_q[2]);
      gg = (r_q[4] & r_q[5]) | (~r_q[4] & r_q[6]);
    end
    tt1 = ff + r_q[3] + ss2 + (wj ^ wj4);
    tt2 = gg + r_q[7] + ss1 + wj;
    nxt = perm1(wj ^ w_q[j4 + 4'd7] ^ rotl32(w_q[j4 + 4'd13], 5'd15))
          ^ rotl32(w_q[j4 + 4'd3], 5'd7) ^ w_q[j4 + 4'd10];
  end

  // Block bytes land big-endian in the window; rounds then roll it in place
  always_ff @(posedge clk_i) begin
    if (cmd_i.buf_we) begin
      w_q[cmd_i.buf_addr[5:2]][{~cmd_i.buf_addr[1:0], 3'b000} +: 8] <= wr_byte;
    end
    if (cmd_i.blk_load) begin
      for (int i = 0; i < 8; i++)
        r_q[i] <= cv_q[255 - 32*i -: 32];
    end else if (cmd_i.round_en) begin
      r_q[3] <= r_q[2];
      r_q[2] <= rotl32(r_q[1], 5'd9);
      r_q[1] <= r_q[0];
      r_q[0] <= tt1;
      r_q[7] <= r_q[6];
      r_q[6] <= rotl32(r_q[5], 5'd19);
      r_q[5] <= r_q[4];
      r_q[4] <= perm0(tt2);
      w_q[j4] <= nxt;
    end
  end

  // Chaining value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= SM3_IV;
    end else if (cmd_i.cv_reset) begin
      cv_q <= SM3_IV;
    end else if (cmd_i.cv_update) begin
      for (int i = 0; i < 8; i++)
        cv_q[255 - 32*i -: 32] <= cv_q[255 - 32*i -: 32] ^ r_q[i];
    end
  end

  assign cv_word_o = cv_q[255 - 32*rd_idx_i -: 32];

endmodule

// ----- rtl/core/sm3_ctrl.sv -----
// Controller: byte intake, padding, round sequencing and digest output.
module sm3_ctrl import sm3_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       in_final_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] out_idx_o,
  input  logic [5:0] pos_i,
  output sm3_cmd_t   cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_FOLD  = 3'd3;
  localparam logic [2:0] ST_PAD   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0] state_q, state_d;
  logic [5:0] rnd_q, rnd_d;
  logic [5:0] paddr_q, paddr_d;
  logic       fin_q, fin_d;     // padding pending after this block
  logic       xtra_q, xtra_d;   // length block pending after this block
  logic       last_q, last_d;   // current compression is the final block
  logic [2:0] oidx_q, oidx_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign out_idx_o   = oidx_q;

  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    paddr_d = paddr_q;
    fin_d   = fin_q;
    xtra_d  = xtra_q;
    last_d  = last_q;
    oidx_d  = oidx_q;
    cmd_o   = '0;
    cmd_o.buf_sel   = BSEL_MSG;
    cmd_o.buf_addr  = pos_i;
    cmd_o.round_idx = rnd_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.buf_we  = 1'b1;
          cmd_o.cnt_add = 1'b1;
          fin_d   = in_final_i;
          paddr_d = pos_i + 6'd1;
          if (pos_i == 6'd63) begin
            last_d  = 1'b0;
            state_d = ST_LOAD;
          end else if (in_final_i) begin
            state_d = ST_PAD;
          end
          if (in_final_i) cmd_o.len_cap = 1'b0;
        end
      end
      ST_LOAD: begin
        cmd_o.blk_load = 1'b1;
        rnd_d   = '0;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.round_en = 1'b1;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'd63) state_d = ST_FOLD;
      end
      ST_FOLD: begin
        cmd_o.cv_update = 1'b1;
        if (last_q) begin
          oidx_d  = '0;
          state_d = ST_OUT;
        end else if (fin_q || xtra_q) begin
          paddr_d = '0;
          xtra_d  = 1'b0;
          state_d = ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_PAD: begin
        // One buffer byte per cycle: mark, zeros, then length
        cmd_o.buf_we   = 1'b1;
        cmd_o.buf_addr = paddr_q;
        if (fin_q) begin
          cmd_o.buf_sel = BSEL_PAD;
          cmd_o.len_cap = 1'b1;
          fin_d = 1'b0;
        end else if (paddr_q >= 6'd56 && last_q) begin
          cmd_o.buf_sel = BSEL_LEN;
        end else begin
          cmd_o.buf_sel = BSEL_ZERO;
        end
        paddr_d = paddr_q + 6'd1;
        if (fin_q) begin
          last_d = (paddr_q < 6'd56);
          xtra_d = (paddr_q >= 6'd56);
        end else if (paddr_q == 6'd55 && !last_q) begin
          last_d = 1'b1;
        end
        if (paddr_q == 6'd63) state_d = ST_LOAD;
      end
      ST_OUT: begin
        if (out_ready_i) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            cmd_o.cv_reset = 1'b1;
            cmd_o.cnt_clr  = 1'b1;
            last_d  = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rnd_q   <= '0;
      paddr_q <= '0;
      fin_q   <= 1'b0;
      xtra_q  <= 1'b0;
      last_q  <= 1'b0;
      oidx_q  <= '0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      paddr_q <= paddr_d;
      fin_q   <= fin_d;
      xtra_q  <= xtra_d;
      last_q  <= last_d;
      oidx_q  <= oidx_d;
    end
  end

endmodule

// ----- rtl/core/sm3_hash_engine.sv -----
// Top level: SM3 hash engine with byte input and digest word output.
// Usage:
//   in_if  carries one message byte per item, final_byte set on the last
//   byte of a message. out_if carries the eight 32-bit digest words,
//   word_index 0 first, last_word set on the eighth.
// Timing:
//   A byte that neither fills a block nor ends a message is taken, and the
//   engine stays ready. The byte that fills a 64-byte block starts a
//   compression (load, 64 rounds, fold) on the single shared round unit;
//   ready stays low meanwhile. After the final byte the padding is written
//   one buffer byte per cycle, followed by one or two compressions; the
//   eight digest words are then offered one per cycle while ready is high.
// Reset: chaining value goes to the SM3 initial value, bit count to zero,
//   the engine is idle and ready.
// Stall: while the receiver holds ready low the current digest word holds;
//   no new byte is taken until all eight words are delivered.
module sm3_hash_engine import sm3_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  sm3_in_if.sink    in_if,
  sm3_out_if.source out_if
);

  sm3_cmd_t    cmd;
  logic [5:0]  pos;
  logic [2:0]  oidx;
  logic [31:0] cv_word;

  sm3_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .in_final_i  (in_if.final_byte),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_idx_o   (oidx),
    .pos_i       (pos),
    .cmd_o       (cmd)
  );

  sm3_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .msg_byte_i (in_if.message_byte),
    .rd_idx_i   (oidx),
    .pos_o      (pos),
    .cv_word_o  (cv_word)
  );

  assign out_if.digest_word = cv_word;
  assign out_if.word_index  = oidx;
  assign out_if.last_word   = (oidx == 3'd7);

endmodule

// ----- rtl/core/sm3_checker.sv -----
// Checker: port-level properties of the SM3 engine, bound to the top level.
module sm3_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_word,
  input logic [2:0]  out_idx,
  input logic        out_last
);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_valid && in_ready && out_valid)) else $error("input taken during digest output");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_idx))
    else $error("digest word changed while stalled");

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_last == (out_idx == 3'd7))) else $error("last flag mismatch");

  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !out_last |=> out_valid && out_idx == $past(out_idx) + 3'd1)
    else $error("digest word order broken");

endmodule

bind sm3_hash_engine sm3_checker u_sm3_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_word  (out_if.digest_word),
  .out_idx   (out_if.word_index),
  .out_last  (out_if.last_word)
);

// ----- sim/sm3_hash_engine_test.sv -----
// Testbench: SM3 byte-stream hash engine checked against its own digest predictor.
module sm3_hash_engine_test;
  import sm3_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  ROW_COUNT   = 6;
  localparam int  CYCLE_LIMIT = 2000000;

  // One expected digest word
  typedef struct {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_word_t;

  // One directed message: a fill byte repeated, a given length
  typedef struct {
    int          msg_len;
    logic [7:0]  fill_byte;
    logic        has_digest;
    logic [31:0] digest_w0;
  } msg_row_t;

  logic clk_i;
  logic rst_ni;
  sm3_in_if  in_if ();
  sm3_out_if out_if ();

  sm3_hash_engine u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  // Predictor state
  logic [31:0]  hash_state [8];
  logic [7:0]   block_bytes [64];
  logic [63:0]  msg_bits;
  digest_word_t digest_queue [$];

  int mismatch_count;
  int words_seen;
  int msgs_sent;
  int bytes_sent;
  longint cycle_count;
  logic   stim_done;

  // Directed rows: "abc"-like single byte, block boundaries around the
  // padding limit, full blocks, 0x00 and 0xff extremes.
  msg_row_t dir_rows [ROW_COUNT] = '{
    '{1,   8'h61, 1'b0, 32'h0},
    '{55,  8'h00, 1'b0, 32'h0},
    '{56,  8'hff, 1'b0, 32'h0},
    '{63,  8'h5a, 1'b0, 32'h0},
    '{64,  8'ha5, 1'b0, 32'h0},
    '{129, 8'hff, 1'b0, 32'h0}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] rot_left(logic [31:0] x, int n);
    n = n % 32;
    if (n == 0) return x;
    return (x << n) | (x >> (32 - n));
  endfunction

  // Standard 64-round compression of block_bytes into hash_state
  task automatic compress_block_bytes();
    logic [31:0] w [68];
    logic [31:0] r [8];
    logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, tj, x;
    for (int i = 0; i < 16; i++)
      w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    for (int i = 16; i < 68; i++) begin
      x = w[i-16] ^ w[i-9] ^ rot_left(w[i-3], 15);
      w[i] = (x ^ rot_left(x, 15) ^ rot_left(x, 23)) ^ rot_left(w[i-13], 7) ^ w[i-6];
    end
    for (int i = 0; i < 8; i++) r[i] = hash_state[i];
    for (int j = 0; j < 64; j++) begin
      tj  = (j < 16) ? TJ_LOW : TJ_HIGH;
      a12 = rot_left(r[0], 12);
      ss1 = rot_left(a12 + r[4] + rot_left(tj, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = r[0] ^ r[1] ^ r[2];
        gg = r[4] ^ r[5] ^ r[6];
      end else begin
        ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
        gg = (r[4] & r[5]) | (~r[4] & r[6]);
      end
      tt1 = ff + r[3] + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + r[7] + ss1 + w[j];
      r[3] = r[2];
      r[2] = rot_left(r[1], 9);
      r[1] = r[0];
      r[0] = tt1;
      r[7] = r[6];
      r[6] = rot_left(r[5], 19);
      r[5] = r[4];
      r[4] = tt2 ^ rot_left(tt2, 9) ^ rot_left(tt2, 17);
    end
    for (int i = 0; i < 8; i++) hash_state[i] ^= r[i];
  endtask

  task automatic reset_hash_state();
    for (int i = 0; i < 8; i++) hash_state[i] = SM3_IV[255 - 32*i -: 32];
    msg_bits = '0;
  endtask

  // Absorb one accepted byte; on the final byte pad and queue the digest
  task automatic absorb_byte(logic [7:0] b, logic fin);
    int pos;
    digest_word_t dw;
    pos = int'(msg_bits[8:3]);
    block_bytes[pos] = b;
    msg_bits += 64'd8;
    pos++;
    if (pos == 64) begin
      compress_block_bytes();
      pos = 0;
    end
    if (!fin) return;
    block_bytes[pos++] = PAD_MARK;
    if (pos > 56) begin
      while (pos < 64) block_bytes[pos++] = 8'h00;
      compress_block_bytes();
      pos = 0;
    end
    while (pos < 56) block_bytes[pos++] = 8'h00;
    for (int i = 0; i < 8; i++) block_bytes[56+i] = msg_bits[63 - 8*i -: 8];
    compress_block_bytes();
    for (int i = 0; i < 8; i++) begin
      dw.digest_word = hash_state[i];
      dw.word_index  = 3'(i);
      dw.last_word   = (i == 7);
      digest_queue.push_back(dw);
    end
    reset_hash_state();
  endtask

  // Offer one byte and wait for it to be taken; valid drops only across a gap
  task automatic send_byte(logic [7:0] b, logic fin);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.message_byte <= b;
    in_if.final_byte   <= fin;
    do @(posedge clk_i); while (!in_if.ready);
    absorb_byte(b, fin);
    bytes_sent++;
  endtask

  task automatic send_message(int len, logic [7:0] fill, bit rand_bytes);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = rand_bytes ? 8'($urandom) : fill;
      send_byte(b, i == len - 1);
    end
    msgs_sent++;
  endtask

  // Stimulus
  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.message_byte = '0;
    in_if.final_byte = 1'b0;
    stim_done = 1'b0;
    msgs_sent = 0;
    bytes_sent = 0;
    reset_hash_state();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int r = 0; r < ROW_COUNT; r++)
      send_message(dir_rows[r].msg_len, dir_rows[r].fill_byte, 1'b0);
    // Random messages, mostly short, a few spanning blocks
    while (bytes_sent < 480) begin
      if ($urandom_range(0, 7) == 0)
        send_message($urandom_range(50, 140), 8'h00, 1'b1);
      else
        send_message($urandom_range(1, 20), 8'h00, 1'b1);
    end
    in_if.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver: random stalls, some stretches always ready
  initial begin
    int stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  // Checker
  always @(posedge clk_i) begin
    digest_word_t exp_w;
    if (rst_ni && out_if.valid && out_if.ready) begin
      words_seen++;
      if (digest_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: unexpected digest word %h", out_if.digest_word);
      end else begin
        exp_w = digest_queue.pop_front();
        if (out_if.digest_word !== exp_w.digest_word ||
            out_if.word_index !== exp_w.word_index ||
            out_if.last_word !== exp_w.last_word) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: word exp %h/%0d/%b got %h/%0d/%b", exp_w.digest_word,
                     exp_w.word_index, exp_w.last_word, out_if.digest_word,
                     out_if.word_index, out_if.last_word);
        end
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles", cycle_count);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // End of run
  initial begin
    mismatch_count = 0;
    words_seen = 0;
    wait (stim_done);
    while (digest_queue.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Hashed %0d messages (%0d bytes), checked %0d digest words, %0d mismatches",
             msgs_sent, bytes_sent, words_seen, mismatch_count);
    if (mismatch_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/sm3_pkg.sv
rtl/core/sm3_if.sv
rtl/core/sm3_datapath.sv
rtl/core/sm3_ctrl.sv
rtl/core/sm3_hash_engine.sv
rtl/core/sm3_checker.sv
sim/sm3_hash_engine_test.sv
